@@ design/jps_pkg.sv @@
// Shared types and constants for the Jacobi five-point stencil sweep core.
`timescale 1ns / 1ps
`default_nettype none
package jps_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int GW_W       = 11;
  localparam int GH_W       = 16;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  typedef logic signed [31:0] val_t;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_COEF_X      = 3'd2,
    CFG_COEF_Y      = 3'd3,
    CFG_DIAG_GAIN   = 3'd4
  } cfg_idx_t;

  // One queued work entry: up to two results plus stencil operands.
  // The lower neighbor is the incoming cell itself (cur).
  typedef struct packed {
    logic has1;
    logic int1;
    logic has2;
    logic last;
    val_t border_val;
    val_t left;
    val_t right;
    val_t up;
    val_t cur;
    val_t rhs;
  } op_t;

  // What travels alongside the arithmetic pipeline.
  typedef struct packed {
    logic has1;
    logic int1;
    logic has2;
    logic last;
    val_t first_val;
    val_t cur;
  } tag_t;

  typedef struct packed {
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [31:0] diag_gain;
  } coef_t;

endpackage
`default_nettype wire

@@ design/jps_front.sv @@
// Front end: raster counters, line stores and classification of each item.
`timescale 1ns / 1ps
`default_nettype none
module jps_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [jps_pkg::GW_W-1:0] grid_width,
  input  wire logic [jps_pkg::GH_W-1:0] grid_height,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire jps_pkg::val_t            in_old_value,
  input  wire jps_pkg::val_t            in_rhs_value,
  input  wire logic [jps_pkg::Q_PTR_W:0] q_free,
  output logic                          push_valid,
  output jps_pkg::op_t                  push_op
);
  import jps_pkg::*;

  logic [GW_W-1:0]   w_cl, wm1;
  logic [GH_W-1:0]   h_cl, hm1;
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [GH_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0] c, c_p1;
  logic [GH_W-1:0]   r;
  logic              row_end, last_row, accept;

  logic [31:0] mem_prev_r [MAX_WIDTH];
  logic [31:0] mem_two_r  [MAX_WIDTH];
  logic [31:0] mem_rhs_r  [MAX_WIDTH];
  logic [31:0] q_center_r, q_right_r, q_up_r, q_rhs_r;

  logic              f1_v_r;
  logic [ADDR_W-1:0] f1_c_r;
  val_t              f1_cur_r;
  logic              f1_has1_r, f1_int1_r, f1_has2_r, f1_last_r;
  val_t              win_left_r;

  always_comb begin
    if (grid_width < GW_W'(3)) begin
      w_cl = GW_W'(3);
    end else if (grid_width > GW_W'(MAX_WIDTH)) begin
      w_cl = GW_W'(MAX_WIDTH);
    end else begin
      w_cl = grid_width;
    end
    wm1  = w_cl - GW_W'(1);
    h_cl = (grid_height < GH_W'(3)) ? GH_W'(3) : grid_height;
    hm1  = h_cl - GH_W'(1);
    row_end  = {1'b0, col_r} >= wm1;
    last_row = row_r >= hm1;
    c    = row_end ? wm1[ADDR_W-1:0] : col_r;
    r    = last_row ? hm1 : row_r;
    c_p1 = c + ADDR_W'(1);
    // one slot is held back for the item sitting in the read stage
    in_ready = q_free > {{Q_PTR_W{1'b0}}, f1_v_r};
    accept   = in_valid && in_ready;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + GH_W'(1);
    end else begin
      col_nxt = col_r + ADDR_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      f1_v_r     <= 1'b0;
      win_left_r <= '0;
    end else begin
      f1_v_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (f1_v_r) begin
        win_left_r <= val_t'(q_center_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_center_r        <= mem_prev_r[c];
      q_right_r         <= mem_prev_r[c_p1];
      q_up_r            <= mem_two_r[c];
      q_rhs_r           <= mem_rhs_r[c];
      mem_prev_r[c]     <= in_old_value;
      mem_rhs_r[c]      <= in_rhs_value;
      f1_c_r            <= c;
      f1_cur_r          <= in_old_value;
      f1_has1_r         <= r != '0;
      f1_int1_r         <= !((r == GH_W'(1)) || (c == '0) || row_end);
      f1_has2_r         <= last_row;
      f1_last_r         <= row_end;
    end
    // center moves down one line once it has been read
    if (f1_v_r) begin
      mem_two_r[f1_c_r] <= q_center_r;
    end
  end

  always_comb begin
    push_valid         = f1_v_r && (f1_has1_r || f1_has2_r);
    push_op.has1       = f1_has1_r;
    push_op.int1       = f1_int1_r;
    push_op.has2       = f1_has2_r;
    push_op.last       = f1_last_r;
    push_op.border_val = val_t'(q_center_r);
    push_op.left       = win_left_r;
    push_op.right      = val_t'(q_right_r);
    push_op.up         = val_t'(q_up_r);
    push_op.cur        = f1_cur_r;
    push_op.rhs        = val_t'(q_rhs_r);
  end

endmodule
`default_nettype wire

@@ design/jps_queue.sv @@
// Short FIFO of work entries between front end and arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module jps_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire jps_pkg::op_t              push_op,
  input  wire logic                      pop,
  output logic                           head_valid,
  output jps_pkg::op_t                   head_op,
  output logic [jps_pkg::Q_PTR_W:0]      q_free
);
  import jps_pkg::*;

  op_t                ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    head_valid = cnt_r != '0;
    head_op    = ent_r[rd_ptr_r];
    q_free     = (Q_PTR_W+1)'(Q_DEPTH) - cnt_r;
    cnt_nxt    = cnt_r + {{Q_PTR_W{1'b0}}, push} - {{Q_PTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && (cnt_r == (Q_PTR_W+1)'(Q_DEPTH))))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && (cnt_r == '0)))
    else $error("queue pop while empty");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + (Q_PTR_W+1)'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

@@ design/jps_back.sv @@
// Back end: stencil arithmetic pipeline and result emitter.
`timescale 1ns / 1ps
`default_nettype none
module jps_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire jps_pkg::coef_t coefs,
  input  wire logic          op_valid,
  input  wire jps_pkg::op_t  op,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jps_pkg::val_t      out_new_value,
  output logic               out_is_interior,
  output logic               out_last_of_grid
);
  import jps_pkg::*;

  logic en, show_first, final_res;

  // stage 1: neighbor sums
  logic               b1_v_r;
  tag_t               b1_tag_r;
  logic signed [32:0] b1_sx_r, b1_sy_r;
  val_t               b1_rhs_r;
  // stage 2: coefficient products
  logic               b2_v_r;
  tag_t               b2_tag_r;
  logic signed [65:0] b2_px_r, b2_py_r;
  val_t               b2_rhs_r;
  // stage 3: tx + ty - rhs
  logic               b3_v_r;
  tag_t               b3_tag_r;
  logic signed [50:0] b3_nd_r, nd_nxt;
  // stage 4: split product with the diagonal gain
  logic               b4_v_r;
  tag_t               b4_tag_r;
  logic signed [51:0] b4_phi_r;
  logic [63:0]        b4_plo_r;
  // stage 5: saturated result
  logic signed [52:0] res;
  val_t               sat_val;
  tag_t               b5_tag;

  logic emit_v_r, sent1_r;
  tag_t emit_r;

  always_comb begin
    show_first = emit_r.has1 && !sent1_r;
    final_res  = !(show_first && emit_r.has2);
    en         = !emit_v_r || (out_ready && final_res);
    pop        = en && op_valid;

    out_valid        = emit_v_r;
    out_new_value    = show_first ? emit_r.first_val : emit_r.cur;
    out_is_interior  = show_first && emit_r.int1;
    out_last_of_grid = !show_first && emit_r.last;

    // arithmetic shifts give floor rounding directly
    nd_nxt = 51'(b2_px_r >>> 16) + 51'(b2_py_r >>> 16)
             - {{19{b2_rhs_r[31]}}, b2_rhs_r};

    // floor(nd * gain / 2^32) = hi * gain + (lo * gain >> 32)
    res = {b4_phi_r[51], b4_phi_r} + {21'd0, b4_plo_r[63:32]};
    if (res > 53'sd2147483647) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (res < -53'sd2147483648) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = res[31:0];
    end
    b5_tag = b4_tag_r;
    if (b4_tag_r.int1) begin
      b5_tag.first_val = sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r   <= 1'b0;
      b2_v_r   <= 1'b0;
      b3_v_r   <= 1'b0;
      b4_v_r   <= 1'b0;
      emit_v_r <= 1'b0;
      sent1_r  <= 1'b0;
    end else if (en) begin
      b1_v_r   <= op_valid;
      b2_v_r   <= b1_v_r;
      b3_v_r   <= b2_v_r;
      b4_v_r   <= b3_v_r;
      emit_v_r <= b4_v_r;
      sent1_r  <= 1'b0;
    end else if (out_valid && out_ready) begin
      sent1_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_tag_r.has1      <= op.has1;
      b1_tag_r.int1      <= op.int1;
      b1_tag_r.has2      <= op.has2;
      b1_tag_r.last      <= op.last;
      b1_tag_r.first_val <= op.border_val;
      b1_tag_r.cur       <= op.cur;
      b1_sx_r  <= {op.left[31], op.left} + {op.right[31], op.right};
      b1_sy_r  <= {op.up[31], op.up} + {op.cur[31], op.cur};
      b1_rhs_r <= op.rhs;

      b2_tag_r <= b1_tag_r;
      b2_px_r  <= b1_sx_r * $signed({1'b0, coefs.coef_x});
      b2_py_r  <= b1_sy_r * $signed({1'b0, coefs.coef_y});
      b2_rhs_r <= b1_rhs_r;

      b3_tag_r <= b2_tag_r;
      b3_nd_r  <= nd_nxt;

      b4_tag_r <= b3_tag_r;
      b4_phi_r <= $signed(b3_nd_r[50:32]) * $signed({1'b0, coefs.diag_gain});
      b4_plo_r <= b3_nd_r[31:0] * coefs.diag_gain;

      emit_r <= b5_tag;
    end
  end

endmodule
`default_nettype wire

@@ design/jacobi_poisson_stencil_sweep_core.sv @@
// Top level of the Jacobi five-point Poisson sweep core.
`timescale 1ns / 1ps
`default_nettype none
// One Jacobi sweep over a raster-ordered grid, one cell (old value, rhs) per
// item. Results come out one row late: an item in row r > 0 yields cell
// (r-1, c); items of the last row also yield their own cell as a border
// pass-through, the final one flagged last_of_grid. The core accepts one item
// per clock while the work queue has room; the three line stores are
// single-write memories read through a register, so input rate is set by
// the front end, while in the last row the output port, giving two results
// per item, holds it back. The first result of an item passes the line store
// read, the work queue, four arithmetic stages and the output register. Line
// stores have no clearing pass; the user must write geometry and coefficients
// only between grids, which the core itself does not enforce.
module jacobi_poisson_stencil_sweep_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire jps_pkg::val_t in_old_value,
  input  wire jps_pkg::val_t in_rhs_value,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jps_pkg::val_t      out_new_value,
  output logic               out_is_interior,
  output logic               out_last_of_grid
);
  import jps_pkg::*;

  logic [GW_W-1:0]  grid_width_r;
  logic [GH_W-1:0]  grid_height_r;
  coef_t            coefs_r;
  logic             push, q_pop, head_valid;
  op_t              push_op, head_op;
  logic [Q_PTR_W:0] q_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r      <= GW_W'(1024);
      grid_height_r     <= GH_W'(1024);
      coefs_r.coef_x    <= 32'd65536;
      coefs_r.coef_y    <= 32'd65536;
      coefs_r.diag_gain <= 32'd1073741824;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width_r      <= cfg_data[GW_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r     <= cfg_data[GH_W-1:0];
        CFG_COEF_X:      coefs_r.coef_x    <= cfg_data;
        CFG_COEF_Y:      coefs_r.coef_y    <= cfg_data;
        CFG_DIAG_GAIN:   coefs_r.diag_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  jps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .grid_width   (grid_width_r),
    .grid_height  (grid_height_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_old_value (in_old_value),
    .in_rhs_value (in_rhs_value),
    .q_free       (q_free),
    .push_valid   (push),
    .push_op      (push_op)
  );

  jps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .q_free     (q_free)
  );

  jps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .coefs            (coefs_r),
    .op_valid         (head_valid),
    .op               (head_op),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_value    (out_new_value),
    .out_is_interior  (out_is_interior),
    .out_last_of_grid (out_last_of_grid)
  );

endmodule
`default_nettype wire
